FILE: rtl/gnno_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gnno_pkg : shared types for the nearest-neighbor pose ordering block
// Word formats, operation codes, controller states and the control/status
// bundles between controller and datapath.
// ============================================================================
package gnno_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam int POS_W  = 16;
    localparam int HEAD_W = 9;
    localparam int TAG_W  = 16;
    localparam int ORD_W  = 6;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [HEAD_W-1:0]        heading;
        logic [TAG_W-1:0]         tag;
    } in_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  out_x;
        logic signed [POS_W-1:0]  out_y;
        logic [HEAD_W-1:0]        out_heading;
        logic [TAG_W-1:0]         out_tag;
        logic [ORD_W-1:0]         order_index;
        logic                     last;
        logic                     overflow;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // accepted load word
        logic start;    // accepted start word
        logic issue;    // read next store entry into the distance pipe
        logic emit;     // commit best pick to the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;   // store empty
        logic scan_done;    // issuing the last stored entry
        logic pick_last;    // current pick is the final one of the run
        logic pipe_empty;   // distance pipe drained, best is final
        logic out_free;     // output register can take a word
    } status_t;

endpackage : gnno_pkg
`default_nettype wire

FILE: rtl/greedy_nearest_neighbor_ordering.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// greedy_nearest_neighbor_ordering : nearest-neighbor pose tour
// Stores poses, then from a start point repeatedly emits the nearest
// remaining pose by squared distance (ties to the earliest load).
// ============================================================================
//
//  channel  | handshake                | word type  | direction
//  ---------+--------------------------+------------+----------
//  pose     | pose_valid / pose_stall  | in_word_t  | in
//  result   | result_valid/result_stall| out_word_t | out
//
//  A load word is accepted while idle; the block stays ready for the next
//  load right away. Loads beyond CAPACITY are dropped and flagged on the
//  overflow bit of the next run's words.
//  A start word with n stored poses runs n passes; each pass streams the
//  store through one memory read port into the distance pipe (memory
//  read, absolute differences, squares; one entry per cycle), drains
//  the pipe and then commits the best pick.
//  pose_stall stays high for the whole run; a start on an empty store
//  leaves the block idle and emits nothing.
//  A stalled result holds the output register; the next pass still runs
//  and waits at commit until the register frees up.
//  Reset clears counters, taken bits and valid flags; store contents are
//  undefined until written.
//
module greedy_nearest_neighbor_ordering #(
    parameter int CAPACITY   = gnno_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = gnno_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pose_valid,
    output logic                pose_stall,
    input  gnno_pkg::in_word_t  pose,
    output logic                result_valid,
    input  logic                result_stall,
    output gnno_pkg::out_word_t result
);
    import gnno_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    start_op;

    // decode of the operation field
    assign start_op = (pose.operation == OP_START);

    gnno_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose_valid),
        .start_op   (start_op),
        .status     (status),
        .pose_stall (pose_stall),
        .cmd        (cmd)
    );

    gnno_dpath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .pose         (pose),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule : greedy_nearest_neighbor_ordering
`default_nettype wire

FILE: rtl/gnno_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gnno_ctrl : run controller
// Takes loads and starts while idle, then sequences scan, drain and emit
// passes until every stored pose has been picked.
// ============================================================================
module gnno_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pose_valid,
    input  logic              start_op,
    input  gnno_pkg::status_t status,
    output logic              pose_stall,
    output gnno_pkg::cmd_t    cmd
);
    import gnno_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pose_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                pose_stall = 1'b0;
                if (pose_valid)
                begin
                    cmd.load  = !start_op;
                    cmd.start = start_op;
                    if (start_op && !status.count_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.pick_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : gnno_ctrl
`default_nettype wire

FILE: rtl/gnno_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// gnno_dpath : pose store and distance datapath
// Pose memory, squared-distance pipe (memory read, differences, squares)
// with running minimum, taken bits, counters and the output register.
// ============================================================================
module gnno_dpath #(
    parameter int CAPACITY   = gnno_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = gnno_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gnno_pkg::in_word_t  pose,
    input  gnno_pkg::cmd_t      cmd,
    input  logic                result_stall,
    output gnno_pkg::status_t   status,
    output logic                result_valid,
    output gnno_pkg::out_word_t result
);
    import gnno_pkg::*;

    localparam int CW     = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SQ_W   = 2 * CW;
    localparam int DIST_W = SQ_W + 1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [HEAD_W-1:0]    heading;
        logic [TAG_W-1:0]     tag;
    } entry_t;

    entry_t mem [CAPACITY];

    logic [CNT_W-1:0]     count_reg;
    logic                 dropped_reg;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [CAPACITY-1:0]  taken_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [IDX_W-1:0]     scan_idx_reg;

    // pipe stage 1: memory read
    logic                 p1_reg;
    logic [IDX_W-1:0]     idx1_reg;
    entry_t               rd_entry_reg;
    // stage 2: absolute differences
    logic                 p2_reg;
    logic                 u2_reg;
    logic [IDX_W-1:0]     idx2_reg;
    entry_t               ent2_reg;
    logic [CW-1:0]        absx2_reg;
    logic [CW-1:0]        absy2_reg;
    // stage 3: squares
    logic                 p3_reg;
    logic                 u3_reg;
    logic [IDX_W-1:0]     idx3_reg;
    entry_t               ent3_reg;
    logic [SQ_W-1:0]      sqx3_reg;
    logic [SQ_W-1:0]      sqy3_reg;
    // running best
    logic                 found_reg;
    logic [DIST_W-1:0]    best_d_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    entry_t               best_reg;

    logic                 result_valid_reg;
    out_word_t            result_reg;

    logic                 full;
    logic [CNT_W-1:0]     count_m1;
    logic [IDX_W-1:0]     last_idx;
    entry_t               wr_entry;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic [CW-1:0]        absx;
    logic [CW-1:0]        absy;
    logic [DIST_W-1:0]    sq_dist;
    logic                 better;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[IDX_W-1:0];

    assign wr_entry.x       = pose.pos_x[CW-1:0];
    assign wr_entry.y       = pose.pos_y[CW-1:0];
    assign wr_entry.heading = pose.heading;
    assign wr_entry.tag     = pose.tag;

    assign dx   = (CW+1)'(cx_reg) - (CW+1)'(rd_entry_reg.x);
    assign dy   = (CW+1)'(cy_reg) - (CW+1)'(rd_entry_reg.y);
    assign absx = dx[CW] ? CW'(-dx) : CW'(dx);
    assign absy = dy[CW] ? CW'(-dy) : CW'(dy);

    assign sq_dist = DIST_W'(sqx3_reg) + DIST_W'(sqy3_reg);
    // strict less-than keeps the lowest index on equal distance
    assign better  = u3_reg && (!found_reg || (sq_dist < best_d_reg));

    assign status.count_zero = (count_reg == '0);
    assign status.scan_done  = (scan_idx_reg == last_idx);
    assign status.pick_last  = (k_reg == last_idx);
    assign status.pipe_empty = !(p1_reg || p2_reg || p3_reg);
    assign status.out_free   = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // pose store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        rd_entry_reg <= mem[scan_idx_reg];
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        idx1_reg  <= scan_idx_reg;
        idx2_reg  <= idx1_reg;
        ent2_reg  <= rd_entry_reg;
        absx2_reg <= absx;
        absy2_reg <= absy;
        idx3_reg  <= idx2_reg;
        ent3_reg  <= ent2_reg;
        sqx3_reg  <= SQ_W'(absx2_reg) * SQ_W'(absx2_reg);
        sqy3_reg  <= SQ_W'(absy2_reg) * SQ_W'(absy2_reg);
        if (better)
        begin
            best_d_reg   <= sq_dist;
            best_idx_reg <= idx3_reg;
            best_reg     <= ent3_reg;
        end
        if (cmd.start)
        begin
            cx_reg <= wr_entry.x;
            cy_reg <= wr_entry.y;
        end
        else if (cmd.emit)
        begin
            cx_reg <= best_reg.x;
            cy_reg <= best_reg.y;
        end
        if (cmd.emit)
        begin
            result_reg.out_x       <= POS_W'(best_reg.x);
            result_reg.out_y       <= POS_W'(best_reg.y);
            result_reg.out_heading <= best_reg.heading;
            result_reg.out_tag     <= best_reg.tag;
            result_reg.order_index <= ORD_W'(k_reg);
            result_reg.last        <= status.pick_last;
            result_reg.overflow    <= dropped_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            taken_reg        <= '0;
            k_reg            <= '0;
            scan_idx_reg     <= '0;
            p1_reg           <= 1'b0;
            p2_reg           <= 1'b0;
            u2_reg           <= 1'b0;
            p3_reg           <= 1'b0;
            u3_reg           <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= cmd.issue;
            p2_reg <= p1_reg;
            u2_reg <= p1_reg && !taken_reg[idx1_reg];
            p3_reg <= p2_reg;
            u3_reg <= u2_reg;

            if (better)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.issue && !status.scan_done)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if (cmd.load)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            if (cmd.start)
            begin
                if (status.count_zero)
                begin
                    dropped_reg <= 1'b0;
                end
                taken_reg    <= '0;
                k_reg        <= '0;
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end

            if (cmd.emit)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
                k_reg                   <= k_reg + IDX_W'(1);
                scan_idx_reg            <= '0;
                found_reg               <= 1'b0;
                if (status.pick_last)
                begin
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                end
            end

            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

endmodule : gnno_dpath
`default_nettype wire
